>>> design/rpy2x_pkg.sv
// shared types, constants and colour conversion for the rgb to packed yuv 2x writer
// no dependencies; used by rpy2x_front, rpy2x_queue, rpy2x_back and the top level

package rpy2x_pkg;

    // largest source frame the counters cover
    localparam int MAX_FRAME_WIDTH  = 1024;
    localparam int MAX_FRAME_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_FRAME_WIDTH);
    localparam int ROW_W = $clog2(MAX_FRAME_HEIGHT);

    // fixed field widths
    localparam int PIX_W  = 32;
    localparam int OFS_W  = 23;
    localparam int WORD_W = 32;
    localparam int FW_W   = 11;
    localparam int IW_W   = 12;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 12;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_INPUT_IS_ARGB32 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORDER_UYVY      = 3'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;

    // register reset values
    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [FW_W-1:0] RST_FRAME_HEIGHT = 11'd240;
    localparam logic [IW_W-1:0] RST_IMAGE_WIDTH  = 12'd640;

    // bt.601 studio range coefficients, q16
    localparam int ACC_W = 26;
    localparam logic signed [ACC_W-1:0] C_Y_R = 26'sd16843;
    localparam logic signed [ACC_W-1:0] C_Y_G = 26'sd33030;
    localparam logic signed [ACC_W-1:0] C_Y_B = 26'sd6423;
    localparam logic signed [ACC_W-1:0] C_U_R = -26'sd9699;
    localparam logic signed [ACC_W-1:0] C_U_G = -26'sd19071;
    localparam logic signed [ACC_W-1:0] C_U_B = 26'sd28770;
    localparam logic signed [ACC_W-1:0] C_V_R = 26'sd28770;
    localparam logic signed [ACC_W-1:0] C_V_G = -26'sd24117;
    localparam logic signed [ACC_W-1:0] C_V_B = -26'sd4653;
    localparam logic signed [ACC_W-1:0] C_OFS_16  = 26'sd1048576;
    localparam logic signed [ACC_W-1:0] C_OFS_128 = 26'sd8388608;

    // configuration write, top level to front
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_cfg_wr;

    // one queued pixel: both destination offsets and the packed word
    typedef struct packed {
        logic [OFS_W-1:0]  ofs_a;
        logic [OFS_W-1:0]  ofs_b;
        logic [WORD_W-1:0] word;
    } t_qent;

    // queue status seen by the write sequencer and the top level
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_qstat;

    // one weighted sum, truncated and clamped to a byte
    function automatic logic [7:0] yuv_chan(
        input logic [7:0]               r,
        input logic [7:0]               g,
        input logic [7:0]               b,
        input logic signed [ACC_W-1:0]  kr,
        input logic signed [ACC_W-1:0]  kg,
        input logic signed [ACC_W-1:0]  kb,
        input logic signed [ACC_W-1:0]  bias
    );
        logic signed [ACC_W-1:0] s;
        logic [7:0]              q;
        s = kr * $signed({18'd0, r}) + kg * $signed({18'd0, g})
          + kb * $signed({18'd0, b}) + bias;
        if (s < 0) begin
            q = 8'd0;
        end else if (s[ACC_W-2:16] > 9'd255) begin
            q = 8'd255;
        end else begin
            q = s[23:16];
        end
        return q;
    endfunction

endpackage

>>> design/rpy2x_front.sv
// front end: configuration registers, colour conversion, packing and offset counters
// depends on rpy2x_pkg

module rpy2x_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpy2x_pkg::t_cfg_wr            i_cfg,
    input  logic                          i_push,
    input  logic [rpy2x_pkg::PIX_W-1:0]   i_pixel,
    output rpy2x_pkg::t_qent              o_ent,
    output logic [rpy2x_pkg::IW_W-1:0]    o_image_width
);
    import rpy2x_pkg::*;

    logic              r_is_argb;
    logic              r_uyvy;
    logic [FW_W-1:0]   r_frame_width;
    logic [FW_W-1:0]   r_frame_height;
    logic [IW_W-1:0]   r_image_width;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [OFS_W-1:0]  r_row_base;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [OFS_W-1:0]  n_row_base;

    logic [COL_W:0]    eff_w;
    logic [ROW_W:0]    eff_h;
    logic [15:0]       c565;
    logic [7:0]        r8, g8, b8;
    logic [7:0]        y8, u8, v8;
    logic [OFS_W-1:0]  ofs_a;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_argb      <= 1'b0;
            r_uyvy         <= 1'b0;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_image_width  <= RST_IMAGE_WIDTH;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_INPUT_IS_ARGB32: r_is_argb      <= i_cfg.data[0];
                REG_ORDER_UYVY:      r_uyvy         <= i_cfg.data[0];
                REG_FRAME_WIDTH:     r_frame_width  <= i_cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_height <= i_cfg.data[FW_W-1:0];
                REG_IMAGE_WIDTH:     r_image_width  <= i_cfg.data[IW_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_image_width = r_image_width;

    // frame size with zero taken as one and oversize saturated
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = (COL_W+1)'(1);
        end else if (32'(r_frame_width) > 32'(MAX_FRAME_WIDTH)) begin
            eff_w = (COL_W+1)'(MAX_FRAME_WIDTH);
        end else begin
            eff_w = (COL_W+1)'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = (ROW_W+1)'(1);
        end else if (32'(r_frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
            eff_h = (ROW_W+1)'(MAX_FRAME_HEIGHT);
        end else begin
            eff_h = (ROW_W+1)'(r_frame_height);
        end
    end

    // argb8888 reduced to rgb565, channels widened by bit replication
    always_comb begin
        if (r_is_argb) begin
            c565 = {i_pixel[23:19], i_pixel[15:10], i_pixel[7:3]};
        end else begin
            c565 = i_pixel[15:0];
        end
        r8 = {c565[15:11], c565[15:13]};
        g8 = {c565[10:5], c565[10:9]};
        b8 = {c565[4:0], c565[4:2]};
    end

    // colour conversion
    assign y8 = yuv_chan(r8, g8, b8, C_Y_R, C_Y_G, C_Y_B, C_OFS_16);
    assign u8 = yuv_chan(r8, g8, b8, C_U_R, C_U_G, C_U_B, C_OFS_128);
    assign v8 = yuv_chan(r8, g8, b8, C_V_R, C_V_G, C_V_B, C_OFS_128);

    // packing and destination offsets of both rows
    assign ofs_a = r_row_base + OFS_W'({r_col, 2'b00});
    always_comb begin
        o_ent.ofs_a = ofs_a;
        o_ent.ofs_b = ofs_a + OFS_W'({r_image_width, 1'b0});
        if (r_uyvy) begin
            o_ent.word = {y8, v8, y8, u8};
        end else begin
            o_ent.word = {v8, y8, u8, y8};
        end
    end

    // column and row counters
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_row_base = r_row_base;
        if ((COL_W+1)'(r_col) + (COL_W+1)'(1) >= eff_w) begin
            n_col = '0;
            if ((ROW_W+1)'(r_row) + (ROW_W+1)'(1) >= eff_h) begin
                n_row      = '0;
                n_row_base = '0;
            end else begin
                n_row      = r_row + ROW_W'(1);
                n_row_base = r_row_base + OFS_W'({r_image_width, 2'b00});
            end
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (i_push) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_base <= n_row_base;
        end
    end

endmodule

>>> design/rpy2x_queue.sv
// two entry queue between the front end and the write sequencer
// depends on rpy2x_pkg

module rpy2x_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rpy2x_pkg::t_qent    i_ent,
    input  logic                i_pop,
    output rpy2x_pkg::t_qent    o_ent,
    output rpy2x_pkg::t_qstat   o_stat
);
    import rpy2x_pkg::*;

    t_qent       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_ent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_ent            = r_mem[r_rptr];
    assign o_stat.full      = r_count[1];
    assign o_stat.not_empty = (r_count != 2'd0);

endmodule

>>> design/rpy2x_back.sv
// write sequencer: emits the upper-row then the lower-row beat of each queued pixel
// depends on rpy2x_pkg

module rpy2x_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpy2x_pkg::t_qent              i_ent,
    input  rpy2x_pkg::t_qstat             i_qstat,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [rpy2x_pkg::OFS_W-1:0]   o_byte_offset,
    output logic [rpy2x_pkg::WORD_W-1:0]  o_packed_word,
    output logic                          o_last_of_pair
);
    import rpy2x_pkg::*;

    logic               r_valid;
    logic               r_last;
    logic [OFS_W-1:0]   r_ofs;
    logic [OFS_W-1:0]   r_ofs_b;
    logic [WORD_W-1:0]  r_word;
    logic               beat_done;

    assign beat_done = r_valid && !i_stall;
    assign o_pop     = i_qstat.not_empty && (!r_valid || (beat_done && r_last));

    // beat control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (beat_done && !r_last) begin
            r_last <= 1'b1;
        end else if (!r_valid || beat_done) begin
            r_valid <= i_qstat.not_empty;
            r_last  <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (beat_done && !r_last) begin
            r_ofs <= r_ofs_b;
        end else if (o_pop) begin
            r_ofs   <= i_ent.ofs_a;
            r_ofs_b <= i_ent.ofs_b;
            r_word  <= i_ent.word;
        end
    end

    assign o_valid        = r_valid;
    assign o_byte_offset  = r_ofs;
    assign o_packed_word  = r_word;
    assign o_last_of_pair = r_last;

endmodule

>>> design/rgb_to_packed_yuv_2x_writer.sv
// Converts RGB565 or ARGB8888 source pixels to BT.601 YUV, packs each as one YUY2/UYVY
// word and writes it to two destination rows, one beat per destination row at the single
// output port. The front end converts and addresses a pixel in the cycle it is accepted;
// the pixel is then written into a two entry queue and popped from there into the output
// register of the write sequencer, from which its first beat is offered. Input stall rises
// only while the queue is full.
// depends on rpy2x_pkg, rpy2x_front, rpy2x_queue, rpy2x_back

module rgb_to_packed_yuv_2x_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rpy2x_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rpy2x_pkg::DATA_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rpy2x_pkg::PIX_W-1:0]   i_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rpy2x_pkg::OFS_W-1:0]   o_byte_offset,
    output logic [rpy2x_pkg::WORD_W-1:0]  o_packed_word,
    output logic                          o_last_of_pair
);
    import rpy2x_pkg::*;

    t_cfg_wr           cfg;
    t_qent             front_ent;
    t_qent             head_ent;
    t_qstat            qstat;
    logic              push;
    logic              pop;
    logic [IW_W-1:0]   image_width;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // input beat accepted while the queue has room
    assign o_stall = qstat.full;
    assign push    = i_valid && !qstat.full;

    rpy2x_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_pixel       (i_pixel),
        .o_ent         (front_ent),
        .o_image_width (image_width)
    );

    rpy2x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (front_ent),
        .i_pop   (pop),
        .o_ent   (head_ent),
        .o_stat  (qstat)
    );

    rpy2x_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ent          (head_ent),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_byte_offset  (o_byte_offset),
        .o_packed_word  (o_packed_word),
        .o_last_of_pair (o_last_of_pair)
    );

`ifndef ASSERT_OFF
    // an upper-row beat is always followed by the lower-row beat of the same pixel
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_pair) |=> (o_valid && o_last_of_pair))
        else $error("lower-row beat missing after upper-row beat");

    // both beats of a pixel carry the same word
    a_pair_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_pair) |=> $stable(o_packed_word))
        else $error("packed word changed within a pixel pair");

    // lower-row offset lies one destination row, twice the image width in bytes, past the upper one
    a_pair_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_pair && !i_cfg_we) |=>
        (o_byte_offset == $past(o_byte_offset) + OFS_W'({image_width, 1'b0})))
        else $error("lower-row offset mismatch");

    // no push into a full queue and no pop from an empty one
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full) && !(pop && !qstat.not_empty))
        else $error("queue overflow or underflow");
`endif

endmodule

>>> tb/tb_rgb_to_packed_yuv_2x_writer.sv
// self-checking testbench for rgb_to_packed_yuv_2x_writer: directed and random pixels,
// predicted yuy2/uyvy words and destination offsets checked beat by beat
// depends on rpy2x_pkg and the rgb_to_packed_yuv_2x_writer design files
`timescale 1ns / 1ps

module tb_rgb_to_packed_yuv_2x_writer;

    import rpy2x_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int STUCK_LIMIT = 2000;
    localparam int OFS_MASK    = (1 << OFS_W) - 1;

    // one destination write as the block should produce it
    typedef struct packed {
        logic [OFS_W-1:0]  ofs;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_dest_write;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [IDX_W-1:0]    i_cfg_idx;
    logic [DATA_W-1:0]   i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [PIX_W-1:0]    i_pixel;
    logic                o_valid;
    logic                i_stall;
    logic [OFS_W-1:0]    o_byte_offset;
    logic [WORD_W-1:0]   o_packed_word;
    logic                o_last_of_pair;

    // expected destination writes, oldest first
    t_dest_write pending_writes[$];

    // predictor copy of the registers and the address counters
    logic        cfg_argb;
    logic        cfg_uyvy;
    logic [10:0] cfg_frame_w;
    logic [10:0] cfg_frame_h;
    logic [11:0] cfg_image_w;
    int          col_pos;
    int          row_pos;
    int          row_base;

    // traffic shaping shared by the source task and the sink process
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int sink_hold_left  = 0;

    // set while the source holds a beat on the input
    bit offering = 1'b0;

    int errors        = 0;
    int pixels_sent   = 0;
    int beats_checked = 0;
    int stuck_cycles  = 0;

    rgb_to_packed_yuv_2x_writer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_offset  (o_byte_offset),
        .o_packed_word  (o_packed_word),
        .o_last_of_pair (o_last_of_pair)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] sat_byte(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // zero counts as one, oversize saturates
    function automatic int eff_size(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pack_yuv(input logic [PIX_W-1:0] pix);
        logic [15:0] c565;
        logic [7:0]  r8, g8, b8, y8, u8, v8;
        int          r, g, b;
        if (cfg_argb) c565 = {pix[23:19], pix[15:10], pix[7:3]};
        else c565 = pix[15:0];
        // widen channels by replicating their top bits
        r8 = {c565[15:11], c565[15:13]};
        g8 = {c565[10:5], c565[10:9]};
        b8 = {c565[4:0], c565[4:2]};
        r = int'(r8);
        g = int'(g8);
        b = int'(b8);
        y8 = sat_byte((16843 * r + 33030 * g + 6423 * b + 16 * 65536) / 65536);
        u8 = sat_byte((-9699 * r - 19071 * g + 28770 * b + 128 * 65536) / 65536);
        v8 = sat_byte((28770 * r - 24117 * g - 4653 * b + 128 * 65536) / 65536);
        if (cfg_uyvy) return {y8, v8, y8, u8};
        return {v8, y8, u8, y8};
    endfunction

    function automatic void predict_writes(input logic [PIX_W-1:0] pix);
        t_dest_write upper, lower;
        int          ofs;
        ofs = (row_base + 4 * col_pos) & OFS_MASK;
        upper.ofs  = ofs[OFS_W-1:0];
        upper.word = pack_yuv(pix);
        upper.last = 1'b0;
        lower      = upper;
        ofs        = (ofs + 2 * int'(cfg_image_w)) & OFS_MASK;
        lower.ofs  = ofs[OFS_W-1:0];
        lower.last = 1'b1;
        pending_writes.push_back(upper);
        pending_writes.push_back(lower);
        // step column, then row, then wrap the frame
        if (col_pos + 1 >= eff_size(int'(cfg_frame_w), MAX_FRAME_WIDTH)) begin
            col_pos = 0;
            if (row_pos + 1 >= eff_size(int'(cfg_frame_h), MAX_FRAME_HEIGHT)) begin
                row_pos  = 0;
                row_base = 0;
            end else begin
                row_pos  = row_pos + 1;
                row_base = (row_base + 4 * int'(cfg_image_w)) & OFS_MASK;
            end
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
        case (idx)
            REG_INPUT_IS_ARGB32: cfg_argb    = data[0];
            REG_ORDER_UYVY:      cfg_uyvy    = data[0];
            REG_FRAME_WIDTH:     cfg_frame_w = data[FW_W-1:0];
            REG_FRAME_HEIGHT:    cfg_frame_h = data[FW_W-1:0];
            REG_IMAGE_WIDTH:     cfg_image_w = data[IW_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sink: checks each output beat and drives stall
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_dest_write exp_wr;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_checked = beats_checked + 1;
            if (pending_writes.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected beat ofs %h word %h last %b", $time,
                         o_byte_offset, o_packed_word, o_last_of_pair);
            end else begin
                exp_wr = pending_writes.pop_front();
                if (o_byte_offset !== exp_wr.ofs) begin
                    errors = errors + 1;
                    $display("%0t: byte_offset expected %h actual %h", $time,
                             exp_wr.ofs, o_byte_offset);
                end
                if (o_packed_word !== exp_wr.word) begin
                    errors = errors + 1;
                    $display("%0t: packed_word expected %h actual %h", $time,
                             exp_wr.word, o_packed_word);
                end
                if (o_last_of_pair !== exp_wr.last) begin
                    errors = errors + 1;
                    $display("%0t: last_of_pair expected %b actual %b", $time,
                             exp_wr.last, o_last_of_pair);
                end
            end
        end
        // long hold-off first, otherwise random stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left = sink_hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck_cycles = 0;
        else stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("rgb_to_packed_yuv_2x_writer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            offering = 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        offering = 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_writes(pix);
        pixels_sent = pixels_sent + 1;
    endtask

    task automatic drain();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // registers change only once every expected beat is out
    task automatic set_config(input logic argb, input logic uyvy, input int fw,
                              input int fh, input int iw);
        drain();
        write_reg(REG_INPUT_IS_ARGB32, DATA_W'(argb));
        write_reg(REG_ORDER_UYVY, DATA_W'(uyvy));
        write_reg(REG_FRAME_WIDTH, DATA_W'(fw));
        write_reg(REG_FRAME_HEIGHT, DATA_W'(fh));
        write_reg(REG_IMAGE_WIDTH, DATA_W'(iw));
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers: rgb565, yuy2, 320 x 240 into 640
    task automatic test_reset_defaults();
        set_traffic(0, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0000_F800);
        send_pixel(32'h0000_07E0);
        send_pixel(32'h0000_001F);
        // upper half ignored in rgb565 mode
        send_pixel(32'hFFFF_0000);
        send_pixel(32'hA5A5_5A5A);
        drain();
    endtask

    // argb8888 reduced to 565, uyvy byte order
    task automatic test_argb_uyvy();
        set_config(1'b1, 1'b1, 320, 240, 640);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_0000);
        send_pixel(32'h0000_FF00);
        send_pixel(32'h0000_00FF);
        // discarded low bits of each channel set
        send_pixel(32'hFF07_0307);
        drain();
    endtask

    // zero sizes act as one, narrow image, oversize saturation
    task automatic test_size_edges();
        set_config(1'b0, 1'b1, 0, 0, 0);
        send_pixel(32'h0000_1234);
        send_pixel(32'h0000_8001);
        set_config(1'b1, 1'b0, 2, 2, 3);
        repeat (5) send_pixel($urandom);
        set_config(1'b0, 1'b0, 2047, 2047, 4095);
        repeat (3) send_pixel($urandom);
        drain();
    endtask

    task automatic test_random_small_frames();
        set_config(1'b0, 1'b0, 3, 2, 6);
        set_traffic(0, 0);
        send_random(90);
        drain();
    endtask

    task automatic test_random_sender_gaps();
        set_config(1'b1, 1'b1, 5, 3, 7);
        set_traffic(74, 0);
        send_random(90);
        drain();
    endtask

    task automatic test_random_sink_stalls();
        set_traffic(0, 74);
        repeat (3) begin
            set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                       int'($urandom_range(1, 4)), int'($urandom_range(1, 4)),
                       int'($urandom_range(2, 12)));
            send_random(30);
        end
        drain();
    endtask

    // sink holds off while the source keeps offering beats
    task automatic test_backpressure();
        set_config(1'b0, 1'b1, 4, 2, 8);
        set_traffic(0, 0);
        sink_hold_left = 80;
        send_random(24);
        drain();
    endtask

    // one pixel per row into the widest image: row base wraps at 2^23
    task automatic test_offset_wrap();
        set_config(1'b1, 1'b0, 1, 1024, 4095);
        set_traffic(35, 35);
        send_random(560);
        drain();
        set_traffic(0, 0);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_INPUT_IS_ARGB32;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_pixel    <= '0;
        cfg_argb    = 1'b0;
        cfg_uyvy    = 1'b0;
        cfg_frame_w = RST_FRAME_WIDTH;
        cfg_frame_h = RST_FRAME_HEIGHT;
        cfg_image_w = RST_IMAGE_WIDTH;
        col_pos     = 0;
        row_pos     = 0;
        row_base    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_argb_uyvy();
        test_size_edges();
        test_random_small_frames();
        test_random_sender_gaps();
        test_random_sink_stalls();
        test_backpressure();
        test_offset_wrap();

        drain();
        repeat (20) @(posedge i_clk);
        if (pending_writes.size() != 0) begin
            errors = errors + 1;
            $display("%0t: %0d expected beats never arrived", $time, pending_writes.size());
        end
        $display("%0d pixels sent, %0d output beats checked", pixels_sent, beats_checked);
        $display("covered rgb565/argb8888, yuy2/uyvy, size wrap and saturation, offset wrap");
        if (errors == 0) begin
            $display("rgb_to_packed_yuv_2x_writer test passed");
        end else begin
            $display("rgb_to_packed_yuv_2x_writer test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/rpy2x_pkg.sv
design/rpy2x_front.sv
design/rpy2x_queue.sv
design/rpy2x_back.sv
design/rgb_to_packed_yuv_2x_writer.sv
tb/tb_rgb_to_packed_yuv_2x_writer.sv
